FILE: rtl/gtd_pkg.sv
// Shared types and constants for the graph twin detector.
// No dependencies; used by the interfaces, the cell and the top level.
package gtd_pkg;

  localparam int ROW_W   = 64;
  localparam int VIDX_W  = 6;
  localparam int CNT_W   = 7;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Work token that walks down the cell row, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [VIDX_W-1:0] qv;
    logic [ROW_W-1:0]  data;    // member mask on add, row of the query vertex on query
    logic [ROW_W-1:0]  result;
  } gtd_token_t;

endpackage

FILE: rtl/gtd_in_if.sv
// Input item channel of the graph twin detector: valid/ready plus payload.
// Depends on gtd_pkg for field widths.
interface gtd_in_if
  import gtd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ROW_W-1:0]  hyperedge_members;
  logic [VIDX_W-1:0] query_vertex;

  modport source(output valid, opcode, hyperedge_members, query_vertex, input ready);
  modport sink(input valid, opcode, hyperedge_members, query_vertex, output ready);
endinterface

FILE: rtl/gtd_out_if.sv
// Result item channel of the graph twin detector: valid/ready plus twin mask.
// Depends on gtd_pkg for field widths.
interface gtd_out_if
  import gtd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] twin_mask;

  modport source(output valid, twin_mask, input ready);
  modport sink(input valid, twin_mask, output ready);
endinterface

FILE: rtl/graph_twin_detector_core.sv
// Graph twin detector. Each accepted item (clear, add hyperedge, query) enters a row of
// MAX_VERTICES cells, each holding one adjacency row, and walks one cell per cycle; its
// result is registered in an output register behind the last cell. One item
// is in flight at a time: in_item.ready returns once the result has been taken.
// The user must see that vertex_count is written through cfg_we/cfg_wdata only while no
// item is in flight; the block itself does not enforce this.
module graph_twin_detector_core
  import gtd_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  gtd_in_if.sink          in_item,
  gtd_out_if.source       out_item
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_eff;
  logic [ROW_W-1:0] vmask;
  logic             busy;
  logic             out_valid;
  logic [ROW_W-1:0] out_mask;
  logic [OP_W-1:0]  out_op;
  logic             in_fire;
  logic             out_fire;

  gtd_token_t head_tok;
  gtd_token_t chain [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] chain_valid;

  assign n_eff = (vertex_count > MaxCnt) ? MaxCnt : vertex_count;
  assign vmask = (n_eff >= CNT_W'(ROW_W)) ? '1 : ((ROW_W'(1) << n_eff) - ROW_W'(1));

  assign in_item.ready   = !busy;
  assign in_fire         = in_item.valid && in_item.ready;
  assign out_item.valid  = out_valid;
  assign out_item.twin_mask = out_mask;
  assign out_fire        = out_valid && out_item.ready;

  always_comb begin
    head_tok.valid  = in_fire;
    head_tok.op     = in_item.opcode;
    head_tok.qv     = in_item.query_vertex;
    head_tok.data   = in_item.hyperedge_members & vmask;
    head_tok.result = '0;
  end

  assign chain[0] = head_tok;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    gtd_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .vmask   (vmask),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
    assign chain_valid[i] = chain[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(64);
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (in_fire) busy <= 1'b1;
      else if (out_fire) busy <= 1'b0;
      if (chain[MAX_VERTICES].valid) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end

  // hold the finished result until taken
  always_ff @(posedge clk) begin
    if (chain[MAX_VERTICES].valid) begin
      out_mask <= chain[MAX_VERTICES].result;
      out_op   <= chain[MAX_VERTICES].op;
    end
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one item in the cell row");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_item.ready |-> (!out_valid && chain_valid == '0))
    else $error("ready while an item is still in flight");

  a_zero_nonquery: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_op != OP_QUERY) |-> (out_mask == '0))
    else $error("nonzero result for a non-query item");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    chain[MAX_VERTICES].valid |-> !out_valid)
    else $error("result overwrites one not yet taken");
`endif

endmodule

FILE: rtl/gtd_cell.sv
// One adjacency cell: holds the row of vertex IDX and acts on the passing token.
// Depends on gtd_pkg.
module gtd_cell
  import gtd_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [ROW_W-1:0] vmask,
  input  gtd_token_t       tok_in,
  output gtd_token_t       tok_out
);

  localparam logic [VIDX_W-1:0] MyIdx = VIDX_W'(IDX);
  localparam logic [ROW_W-1:0]  MyBit = ROW_W'(1) << IDX;

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [ROW_W-1:0] row_m;
  logic [ROW_W-1:0] qbit;
  gtd_token_t       tok_next;

  assign row_m = row & vmask;
  assign qbit  = ROW_W'(1) << tok_in.qv;

  always_comb begin
    row_next = row;
    tok_next = tok_in;
    if (tok_in.valid) begin
      unique case (tok_in.op)
        OP_CLEAR: row_next = '0;
        OP_ADD: begin
          if (tok_in.data[IDX]) row_next = row | (tok_in.data & ~MyBit);
        end
        OP_QUERY: begin
          // pick up the query row here; later cells compare against it
          if (tok_in.qv == MyIdx) tok_next.data = row_m;
          if (MyIdx > tok_in.qv && vmask[IDX] &&
              (tok_in.data & ~MyBit) == (row_m & ~qbit)) begin
            tok_next.result = tok_in.result | MyBit;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      tok_out <= '0;
    end else begin
      row     <= row_next;
      tok_out <= tok_next;
    end
  end

endmodule
